// ===== hw/rtl/gray_gradient_edge_threshold_assert.svh =====
// Assertion macros shared by the edge detector RTL.
`ifndef GRAY_GRADIENT_EDGE_THRESHOLD_ASSERT_SVH
`define GRAY_GRADIENT_EDGE_THRESHOLD_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define GGEDGE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ggedge assertion failed");

// Check a property on every clock edge, reset included.
`define GGEDGE_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ggedge assertion failed");

`else

`define GGEDGE_ASSERT(lbl, prop)
`define GGEDGE_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== hw/rtl/ggedge_pkg.sv =====
// Shared constants and types of the gray gradient edge detector.
package ggedge_pkg;

    localparam int IMAGE_SIDE = 256;
    localparam int POS_W      = $clog2(IMAGE_SIDE);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(IMAGE_SIDE - 1);

    localparam int PIX_W = 8;

    // gray = (30r + 59g + 11b) / 100, the divide done as multiply by 5243 >> 19,
    // exact for every sum below 43690 (the sum never exceeds 25500)
    localparam int SUM_W   = 15;
    localparam int RECIP_W = 13;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [SUM_W-1:0]   GRAY_R_WT  = SUM_W'(30);
    localparam logic [SUM_W-1:0]   GRAY_G_WT  = SUM_W'(59);
    localparam logic [SUM_W-1:0]   GRAY_B_WT  = SUM_W'(11);
    localparam logic [RECIP_W-1:0] GRAY_RECIP = RECIP_W'(5243);
    localparam int GRAY_SHIFT = 19;

    localparam logic [PIX_W-1:0] THRESHOLD_RESET = PIX_W'(30);
    localparam logic [PIX_W-1:0] EDGE_VALUE      = PIX_W'(0);
    localparam logic [PIX_W-1:0] NON_EDGE_VALUE  = PIX_W'(255);

    localparam int RES_SLOTS = 3;
    localparam int CNT_W     = 2;

    // Up to three results of one pixel word, slot 0 first.
    typedef struct packed {
        logic [RES_SLOTS-1:0] edge_bits;
        logic [RES_SLOTS-1:0] last_bits;
        logic [CNT_W-1:0]     count;
    } res_t;

endpackage

// ===== hw/rtl/ggedge_gray_conv.sv =====
// Luma conversion of one RGB pixel to an 8-bit gray level.
module ggedge_gray_conv (
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic [7:0] gray
);
    import ggedge_pkg::*;

    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;

    always_comb
    begin
        sum  = SUM_W'(red) * GRAY_R_WT + SUM_W'(green) * GRAY_G_WT
             + SUM_W'(blue) * GRAY_B_WT;
        prod = PROD_W'(sum) * PROD_W'(GRAY_RECIP);
        gray = prod[GRAY_SHIFT +: PIX_W];
    end

endmodule

// ===== hw/rtl/ggedge_line_buf.sv =====
// One-row line buffer of gray levels with two registered read ports.
module ggedge_line_buf (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [ggedge_pkg::POS_W-1:0] rd_addr_a,
    input  logic [ggedge_pkg::POS_W-1:0] rd_addr_b,
    output logic [ggedge_pkg::PIX_W-1:0] rd_data_a,
    output logic [ggedge_pkg::PIX_W-1:0] rd_data_b,
    input  logic                         wr_en,
    input  logic [ggedge_pkg::POS_W-1:0] wr_addr,
    input  logic [ggedge_pkg::PIX_W-1:0] wr_data
);
    import ggedge_pkg::*;

    logic [PIX_W-1:0] mem [IMAGE_SIDE];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ===== hw/rtl/ggedge_out_queue.sv =====
// Result register holding up to three results, drained one per handshake.
`include "gray_gradient_edge_threshold_assert.svh"

module ggedge_out_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  ggedge_pkg::res_t             res,
    output logic                         free,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ggedge_pkg::PIX_W-1:0] edge_value,
    output logic                         frame_last
);
    import ggedge_pkg::*;

    logic [RES_SLOTS-1:0] edge_reg, edge_next;
    logic [RES_SLOTS-1:0] last_reg, last_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 take;

    always_comb
    begin
        take      = out_valid && out_ready;
        free      = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && out_ready);
        edge_next = edge_reg;
        last_next = last_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            edge_next = res.edge_bits;
            last_next = res.last_bits;
            cnt_next  = res.count;
        end
        else if (take)
        begin
            // advance to the next slot
            edge_next = {1'b0, edge_reg[RES_SLOTS-1:1]};
            last_next = {1'b0, last_reg[RES_SLOTS-1:1]};
            cnt_next  = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            last_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        edge_reg <= edge_next;
    end

    assign out_valid  = (cnt_reg != '0);
    assign edge_value = edge_reg[0] ? EDGE_VALUE : NON_EDGE_VALUE;
    assign frame_last = out_valid && last_reg[0];

    `GGEDGE_ASSERT(a_load_only_when_free, load |-> free)
    `GGEDGE_ASSERT(a_last_is_final_slot,
        (out_valid && last_reg[0]) |-> (cnt_reg == CNT_W'(1)))

endmodule

// ===== hw/rtl/gray_gradient_edge_threshold.sv =====
// Top level of the gray gradient edge detector.
//
// Pixel words enter on in_valid/in_ready (red, green, blue) in raster order of
// a square IMAGE_SIDE x IMAGE_SIDE frame; result words leave on
// out_valid/out_ready (edge_value 0 = edge, 255 = flat; frame_last marks the
// bottom-right pixel). The threshold is written with cfg_we/cfg_data, no
// handshake. A pixel's result needs its lower neighbour, so results of a row
// leave while the next row enters: the result for pixel (r,c) is formed in the
// input stage from pixel (r+1,c), then held in the result register. The bottom
// row's results leave as it arrives. Throughput is one word per cycle while
// the receiver is ready; on the bottom row each pixel past the first column
// gives two results (three at the last column), so input is taken at the rate
// the single output port drains the three-slot result register.
// Reset clears the row/column counters (next word starts a frame) and sets
// the threshold to 30. A stalled receiver holds the result register; the
// input stage then holds its word and drops in_ready, nothing is lost.
`include "gray_gradient_edge_threshold_assert.svh"

module gray_gradient_edge_threshold (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] edge_value,
    output logic       frame_last,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data
);
    import ggedge_pkg::*;

    // position of the next pixel word
    logic [POS_W-1:0] row_reg, row_next;
    logic [POS_W-1:0] col_reg, col_next;

    // input stage: one pixel word and its position flags
    logic             s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0] s1_red_reg, s1_green_reg, s1_blue_reg;
    logic [POS_W-1:0] s1_col_reg;
    logic             s1_row_first_reg, s1_row_last_reg;
    logic             s1_col_first_reg, s1_col_last_reg;

    logic [PIX_W-1:0] prev_gray_reg;
    logic [PIX_W-1:0] thr_reg;

    logic             accept;
    logic             s1_adv;
    logic             q_free;
    logic             col_last;
    logic [POS_W-1:0] rd_addr_right;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] above_right;
    logic [PIX_W-1:0] gray;
    logic             edge_up;
    logic             edge_left;
    res_t             res;

    function automatic logic diff_ge(input logic [PIX_W-1:0] a,
                                     input logic [PIX_W-1:0] b,
                                     input logic [PIX_W-1:0] thr);
        logic [PIX_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d >= thr;
    endfunction

    ggedge_gray_conv u_gray (
        .red   (s1_red_reg),
        .green (s1_green_reg),
        .blue  (s1_blue_reg),
        .gray  (gray)
    );

    // read the row above at accept, write this row as the word leaves stage 1
    ggedge_line_buf u_line (
        .clk       (clk),
        .rd_en     (accept),
        .rd_addr_a (col_reg),
        .rd_addr_b (rd_addr_right),
        .rd_data_a (above),
        .rd_data_b (above_right),
        .wr_en     (s1_adv),
        .wr_addr   (s1_col_reg),
        .wr_data   (gray)
    );

    always_comb
    begin
        col_last      = (col_reg == POS_LAST);
        rd_addr_right = col_last ? '0 : col_reg + POS_W'(1);

        // result for the pixel above: compare down, and right unless at the border
        edge_up = diff_ge(above, gray, thr_reg)
               || (!s1_col_last_reg && diff_ge(above, above_right, thr_reg));
        // bottom row: result for the pixel to the left, compared right only
        edge_left = diff_ge(prev_gray_reg, gray, thr_reg);

        res.edge_bits = {1'b0, edge_left, edge_up};
        res.last_bits = {1'b1, 2'b00};
        if (s1_row_first_reg)
        begin
            res.count = CNT_W'(0);
        end
        else if (!s1_row_last_reg || s1_col_first_reg)
        begin
            res.count = CNT_W'(1);
        end
        else if (!s1_col_last_reg)
        begin
            res.count = CNT_W'(2);
        end
        else
        begin
            res.count = CNT_W'(3);
        end

        s1_adv   = s1_valid_reg && ((res.count == '0) || q_free);
        in_ready = !s1_valid_reg || s1_adv;
        accept   = in_valid && in_ready;

        s1_valid_next = accept || (s1_valid_reg && !s1_adv);

        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = (row_reg == POS_LAST) ? '0 : row_reg + POS_W'(1);
            end
            else
            begin
                col_next = col_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            prev_gray_reg <= '0;
            thr_reg       <= THRESHOLD_RESET;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_valid_reg <= s1_valid_next;
            if (s1_adv)
            begin
                prev_gray_reg <= gray;
            end
            if (cfg_we)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    // hold the stage-1 payload until it advances
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_red_reg       <= red;
            s1_green_reg     <= green;
            s1_blue_reg      <= blue;
            s1_col_reg       <= col_reg;
            s1_row_first_reg <= (row_reg == '0);
            s1_row_last_reg  <= (row_reg == POS_LAST);
            s1_col_first_reg <= (col_reg == '0);
            s1_col_last_reg  <= col_last;
        end
    end

    ggedge_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (s1_adv && (res.count != '0)),
        .res        (res),
        .free       (q_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .edge_value (edge_value),
        .frame_last (frame_last)
    );

    `GGEDGE_ASSERT(a_pos_in_range, (row_reg <= POS_LAST) && (col_reg <= POS_LAST))
    `GGEDGE_ASSERT(a_frame_wrap,
        (accept && col_last && (row_reg == POS_LAST)) |=> ((row_reg == '0) && (col_reg == '0)))

endmodule
